// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level to check the union-find block.
// Depends on nothing; each macro takes the clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/uf_pkg.sv =====
// Shared constants and types for the union-find component counter.
// Used by uf_node_store, uf_ctrl and the top level; depends on nothing.
package uf_pkg;

    // Table size and derived widths.
    localparam int MAX_NODES = 32;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);

    // Configuration register map.
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT = 1'b0;
    localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(26);

    // Command codes.
    localparam logic CMD_CLEAR = 1'b0;
    localparam logic CMD_UNION = 1'b1;

    // One table entry: set size when a root, parent index otherwise.
    typedef struct packed {
        logic             is_root;
        logic [CNT_W-1:0] link;
    } t_node_entry;

    localparam t_node_entry ENTRY_RESET = '{is_root: 1'b1, link: CNT_W'(1)};

    // Access request from the controller to the node store.
    typedef struct packed {
        logic              clear;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        t_node_entry       wr_data;
    } t_store_req;

endpackage

// ===== rtl/union_find_component_counter.sv =====
// Union-find component counter. A clear or a flagged union goes straight to the finish state,
// which loads the result register; a union walks from each of its two nodes to the root
// (one memory read a step) and, when it merges, writes the surviving root, node b and the other root.
// A result waits while the output register still holds one that is not yet taken.
// One item at a time; ready returns in the cycle the result first shows valid.
// Synchronous active-low reset: every node a singleton, 26 nodes and 26 components.
`include "assert_macros.svh"

module union_find_component_counter import uf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input channel.
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_command,
    input  logic [IDX_W-1:0]     i_node_a,
    input  logic [IDX_W-1:0]     i_node_b,
    // Output channel.
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [CNT_W-1:0]     o_components,
    output logic                 o_merged,
    output logic                 o_bad_index,
    // Configuration port.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [REG_IDX_W+1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [CNT_W-1:0]     r_node_count;
    logic [REG_IDX_W-1:0] reg_idx;
    t_store_req           store_req;
    t_node_entry          rd_entry;

    assign reg_idx = paddr[REG_IDX_W+1:2];
    assign pready  = 1'b1;

    // Register write on the access phase of a write transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (reg_idx == REG_NODE_COUNT)) begin
            r_node_count <= pwdata[CNT_W-1:0];
        end
    end

    // Register read.
    always_comb begin
        prdata = '0;
        if (reg_idx == REG_NODE_COUNT) begin
            prdata = 32'(r_node_count);
        end
    end

    uf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_node_a     (i_node_a),
        .i_node_b     (i_node_b),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_components (o_components),
        .o_merged     (o_merged),
        .o_bad_index  (o_bad_index),
        .i_node_count (r_node_count),
        .o_req        (store_req),
        .i_rd_entry   (rd_entry)
    );

    uf_node_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (store_req),
        .o_rd_entry (rd_entry)
    );

    // An accepted transaction keeps the sequencer busy for at least the next cycle.
    `UF_ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "item overlap")
    // A flagged union never reports a merge.
    `UF_ASSERT_IMP(a_bad_no_merge, i_clk, i_rst_n, o_valid, !(o_merged && o_bad_index), "bad merge")
    // The component count never exceeds the table size.
    `UF_ASSERT_IMP(a_count_range, i_clk, i_rst_n, o_valid, o_components <= CNT_W'(MAX_NODES), "count range")

endmodule

// ===== rtl/uf_node_store.sv =====
// Node table of the union-find block: a synchronous memory with registered reads.
// Per-entry valid flags let a clear reset every entry with one write of the flags. Depends on uf_pkg.
module uf_node_store import uf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_store_req  i_req,
    output t_node_entry o_rd_entry
);

    t_node_entry          r_mem [MAX_NODES];
    logic [MAX_NODES-1:0] r_valid;
    t_node_entry          r_rd_data;
    logic                 r_rd_valid;

    // Memory write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    // Valid flags: an entry never written since the last clear reads as a singleton root.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.clear) begin
                r_valid <= '0;
            end else if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rd_entry = r_rd_valid ? r_rd_data : ENTRY_RESET;

endmodule

// ===== rtl/uf_ctrl.sv =====
// Sequencer of the union-find block: root walks, link updates and the result register.
// Drives uf_node_store through a t_store_req; depends on uf_pkg.
module uf_ctrl import uf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Input channel.
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_command,
    input  logic [IDX_W-1:0] i_node_a,
    input  logic [IDX_W-1:0] i_node_b,
    // Output channel.
    output logic             o_valid,
    input  logic             i_ready,
    output logic [CNT_W-1:0] o_components,
    output logic             o_merged,
    output logic             o_bad_index,
    // Configuration and node store.
    input  logic [CNT_W-1:0] i_node_count,
    output t_store_req       o_req,
    input  t_node_entry      i_rd_entry
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_WALK_A = 7'b0000010,
        ST_WALK_B = 7'b0000100,
        ST_WR_RA  = 7'b0001000,
        ST_WR_B   = 7'b0010000,
        ST_WR_RB  = 7'b0100000,
        ST_FINISH = 7'b1000000
    } t_state;

    localparam logic [CNT_W-1:0] STEP_LIMIT = CNT_W'(MAX_NODES);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cur, n_cur;
    logic [CNT_W-1:0] r_steps, n_steps;
    logic [IDX_W-1:0] r_node_b, n_node_b;
    logic [IDX_W-1:0] r_root_a, n_root_a;
    logic [IDX_W-1:0] r_root_b, n_root_b;
    logic [CNT_W-1:0] r_size_a, n_size_a;
    logic [CNT_W-1:0] r_size_b, n_size_b;
    logic [CNT_W-1:0] r_in_use, n_in_use;
    logic [CNT_W-1:0] r_total, n_total;
    logic             r_merged, n_merged;
    logic             r_bad, n_bad;
    logic             r_out_valid, n_out_valid;
    logic [CNT_W-1:0] r_out_components, n_out_components;
    logic             r_out_merged, n_out_merged;
    logic             r_out_bad, n_out_bad;

    logic             walk_done;
    logic [IDX_W-1:0] walk_next;
    logic [CNT_W-1:0] sat_count;

    // The walk stops at a root, or after as many steps as the table has entries.
    assign walk_done = i_rd_entry.is_root || (r_steps == STEP_LIMIT);
    assign walk_next = i_rd_entry.link[IDX_W-1:0];
    assign sat_count = (i_node_count > STEP_LIMIT) ? STEP_LIMIT : i_node_count;

    // Next-state and store request logic.
    always_comb begin
        n_state          = r_state;
        n_cur            = r_cur;
        n_steps          = r_steps;
        n_node_b         = r_node_b;
        n_root_a         = r_root_a;
        n_root_b         = r_root_b;
        n_size_a         = r_size_a;
        n_size_b         = r_size_b;
        n_in_use         = r_in_use;
        n_total          = r_total;
        n_merged         = r_merged;
        n_bad            = r_bad;
        n_out_valid      = r_out_valid;
        n_out_components = r_out_components;
        n_out_merged     = r_out_merged;
        n_out_bad        = r_out_bad;
        o_req            = '0;

        // The result register empties when its transaction completes.
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_merged = 1'b0;
                    n_bad    = 1'b0;
                    if (i_command == CMD_CLEAR) begin
                        o_req.clear = 1'b1;
                        n_in_use    = sat_count;
                        n_total     = sat_count;
                        n_state     = ST_FINISH;
                    end else if (({1'b0, i_node_a} >= r_in_use) ||
                                 ({1'b0, i_node_b} >= r_in_use)) begin
                        n_bad   = 1'b1;
                        n_state = ST_FINISH;
                    end else begin
                        o_req.rd_en   = 1'b1;
                        o_req.rd_addr = i_node_a;
                        n_cur         = i_node_a;
                        n_steps       = '0;
                        n_node_b      = i_node_b;
                        n_state       = ST_WALK_A;
                    end
                end
            end
            ST_WALK_A: begin
                if (walk_done) begin
                    n_root_a      = r_cur;
                    n_size_a      = i_rd_entry.link;
                    o_req.rd_en   = 1'b1;
                    o_req.rd_addr = r_node_b;
                    n_cur         = r_node_b;
                    n_steps       = '0;
                    n_state       = ST_WALK_B;
                end else begin
                    o_req.rd_en   = 1'b1;
                    o_req.rd_addr = walk_next;
                    n_cur         = walk_next;
                    n_steps       = r_steps + CNT_W'(1);
                end
            end
            ST_WALK_B: begin
                if (walk_done) begin
                    if (r_cur != r_root_a) begin
                        n_root_b = r_cur;
                        n_size_b = i_rd_entry.link;
                        n_state  = ST_WR_RA;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end else begin
                    o_req.rd_en   = 1'b1;
                    o_req.rd_addr = walk_next;
                    n_cur         = walk_next;
                    n_steps       = r_steps + CNT_W'(1);
                end
            end
            ST_WR_RA: begin
                // The surviving root takes the combined size.
                o_req.wr_en           = 1'b1;
                o_req.wr_addr         = r_root_a;
                o_req.wr_data.is_root = 1'b1;
                o_req.wr_data.link    = r_size_a + r_size_b;
                n_state               = ST_WR_B;
            end
            ST_WR_B: begin
                o_req.wr_en           = 1'b1;
                o_req.wr_addr         = r_node_b;
                o_req.wr_data.is_root = 1'b0;
                o_req.wr_data.link    = CNT_W'(r_root_a);
                n_state               = ST_WR_RB;
            end
            ST_WR_RB: begin
                o_req.wr_en           = 1'b1;
                o_req.wr_addr         = r_root_b;
                o_req.wr_data.is_root = 1'b0;
                o_req.wr_data.link    = CNT_W'(r_root_a);
                if (r_total != '0) begin
                    n_total = r_total - CNT_W'(1);
                end
                n_merged = 1'b1;
                n_state  = ST_FINISH;
            end
            ST_FINISH: begin
                // Load the result once the output register is free.
                if (!r_out_valid || i_ready) begin
                    n_out_valid      = 1'b1;
                    n_out_components = r_total;
                    n_out_merged     = r_merged;
                    n_out_bad        = r_bad;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_in_use    <= NODE_COUNT_RESET;
            r_total     <= NODE_COUNT_RESET;
            r_merged    <= 1'b0;
            r_bad       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_in_use    <= n_in_use;
            r_total     <= n_total;
            r_merged    <= n_merged;
            r_bad       <= n_bad;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cur            <= n_cur;
        r_steps          <= n_steps;
        r_node_b         <= n_node_b;
        r_root_a         <= n_root_a;
        r_root_b         <= n_root_b;
        r_size_a         <= n_size_a;
        r_size_b         <= n_size_b;
        r_out_components <= n_out_components;
        r_out_merged     <= n_out_merged;
        r_out_bad        <= n_out_bad;
    end

    assign o_ready      = (r_state == ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_components = r_out_components;
    assign o_merged     = r_out_merged;
    assign o_bad_index  = r_out_bad;

endmodule

// ===== bench/uf_component_checker.sv =====
`timescale 1ns / 1ps
// Checker for the union-find component counter: tracks node_count writes, predicts results.
// Depends on uf_pkg; watches the input, output and configuration transactions of the block.
module uf_component_checker import uf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input channel, as seen at the block.
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic                 i_command,
    input  logic [IDX_W-1:0]     i_node_a,
    input  logic [IDX_W-1:0]     i_node_b,
    // Output channel, as seen at the block.
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [CNT_W-1:0]     i_components,
    input  logic                 i_merged,
    input  logic                 i_bad_index,
    // Configuration port.
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [REG_IDX_W+1:0] i_paddr,
    input  logic [31:0]          i_pwdata,
    input  logic                 i_pready,
    // Status for the testbench top.
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [CNT_W-1:0] components;
        logic             merged;
        logic             bad_index;
    } t_uf_result;

    // Mirror of the forest, the register and the counters.
    t_node_entry      forest [MAX_NODES];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] live_nodes;
    logic [CNT_W-1:0] component_sum;
    t_uf_result       result_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Every node back to a singleton; the node count is latched, saturated at the table size.
    task automatic clear_forest();
        int n;
        for (n = 0; n < MAX_NODES; n++) begin
            forest[n] = ENTRY_RESET;
        end
        live_nodes    = (count_reg > MAX_NODES) ? CNT_W'(MAX_NODES) : count_reg;
        component_sum = live_nodes;
    endtask

    // Follow parent links until a root, never more steps than the table holds.
    function automatic logic [IDX_W-1:0] root_of(input logic [IDX_W-1:0] start);
        logic [IDX_W-1:0] cur;
        int               step;
        cur = start;
        for (step = 0; step < MAX_NODES && !forest[cur].is_root; step++) begin
            cur = forest[cur].link[IDX_W-1:0];
        end
        return cur;
    endfunction

    // Apply one accepted transaction to the mirror and queue the result it must give.
    task automatic predict_components(input logic cmd, input logic [IDX_W-1:0] a,
                                      input logic [IDX_W-1:0] b);
        t_uf_result       res;
        logic [IDX_W-1:0] ra;
        logic [IDX_W-1:0] rb;
        res = '0;
        if (cmd == CMD_CLEAR) begin
            clear_forest();
        end else if (a >= live_nodes || b >= live_nodes) begin
            res.bad_index = 1'b1;
        end else begin
            ra = root_of(a);
            rb = root_of(b);
            if (ra != rb) begin
                forest[ra].link = forest[ra].link + forest[rb].link;
                forest[b]       = '{is_root: 1'b0, link: CNT_W'(ra)};
                forest[rb]      = '{is_root: 1'b0, link: CNT_W'(ra)};
                if (component_sum != '0) begin
                    component_sum = component_sum - 1'b1;
                end
                res.merged = 1'b1;
            end
        end
        res.components = component_sum;
        result_q.push_back(res);
    endtask

    // Compare one result transaction with the oldest expectation.
    task automatic check_components();
        t_uf_result want;
        if (result_q.size() == 0) begin
            $display("%0t: unexpected result: components %0d merged %0b bad_index %0b",
                     $time, i_components, i_merged, i_bad_index);
            o_fail_count++;
        end else begin
            want = result_q.pop_front();
            if (i_components !== want.components) begin
                $display("%0t: components mismatch: expected %0d, actual %0d",
                         $time, want.components, i_components);
                o_fail_count++;
            end
            if (i_merged !== want.merged) begin
                $display("%0t: merged mismatch: expected %0b, actual %0b",
                         $time, want.merged, i_merged);
                o_fail_count++;
            end
            if (i_bad_index !== want.bad_index) begin
                $display("%0t: bad_index mismatch: expected %0b, actual %0b",
                         $time, want.bad_index, i_bad_index);
                o_fail_count++;
            end
        end
    endtask

    // Sample every transaction at the rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            count_reg = NODE_COUNT_RESET;
            clear_forest();
            result_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr == {REG_NODE_COUNT, 2'b00}) begin
                count_reg = i_pwdata[CNT_W-1:0];
            end
            if (i_out_valid && i_out_ready) begin
                check_components();
            end
            if (i_in_valid && i_in_ready) begin
                predict_components(i_command, i_node_a, i_node_b);
            end
        end
        o_pending = result_q.size();
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the union-find component counter: clock, reset, stimulus and verdict.
// Depends on uf_pkg, the block and uf_component_checker, which predicts and compares.
module tb_top;
    import uf_pkg::*;

    localparam int ITEM_TARGET = 850;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 i_valid   = 1'b0;
    logic                 o_ready;
    logic                 i_command = CMD_CLEAR;
    logic [IDX_W-1:0]     i_node_a  = '0;
    logic [IDX_W-1:0]     i_node_b  = '0;
    logic                 o_valid;
    logic                 i_ready   = 1'b0;
    logic [CNT_W-1:0]     o_components;
    logic                 o_merged;
    logic                 o_bad_index;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [REG_IDX_W+1:0] paddr     = '0;
    logic [31:0]          pwdata    = '0;
    logic [31:0]          prdata;
    logic                 pready;
    int                   fail_count;
    int                   pending;

    // Idle rates in percent, and what the stimulus knows of the block's setting.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int sent_items     = 0;
    int count_setting  = 26;
    int live_count     = 26;
    int chain_pos      = 0;

    union_find_component_counter DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_node_a     (i_node_a),
        .i_node_b     (i_node_b),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_components (o_components),
        .o_merged     (o_merged),
        .o_bad_index  (o_bad_index),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    uf_component_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_command    (i_command),
        .i_node_a     (i_node_a),
        .i_node_b     (i_node_b),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_components (o_components),
        .i_merged     (o_merged),
        .i_bad_index  (o_bad_index),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver stalls at random at the current rate.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Give up if the run hangs.
    initial begin
        #20_000_000;
        $display("union_find_component_counter verification failed");
        $finish;
    end

    // Send one transaction after a random gap; valid stays high after acceptance
    // so that back-to-back transactions never lower and raise it in one step.
    task automatic send_item(input logic cmd, input logic [IDX_W-1:0] a,
                             input logic [IDX_W-1:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_node_a  <= a;
        i_node_b  <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent_items++;
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (3) @(posedge i_clk);
    endtask

    // Drain, then write node_count through a setup and an access cycle.
    task automatic write_node_count(input int value);
        hold_until_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_NODE_COUNT, 2'b00};
        pwdata  <= {26'($urandom()), 6'(value)};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        count_setting = value & 63;
    endtask

    // A clear, with random don't-care node fields.
    task automatic send_clear();
        send_item(CMD_CLEAR, IDX_W'($urandom()), IDX_W'($urandom()));
        live_count = (count_setting > MAX_NODES) ? MAX_NODES : count_setting;
        chain_pos  = 0;
    endtask

    // Pick a union: mostly valid nodes, some chain links to grow deep trees,
    // some repeats of one node, and some random indices that may be out of range.
    task automatic send_random_union();
        int kind;
        int a;
        int b;
        kind = $urandom_range(0, 99);
        if (live_count == 0 || kind < 12) begin
            a = $urandom_range(0, MAX_NODES - 1);
            b = $urandom_range(0, MAX_NODES - 1);
        end else if (kind < 35 && live_count >= 2) begin
            if (chain_pos >= live_count - 1) begin
                chain_pos = 0;
            end
            a = chain_pos + 1;
            b = chain_pos;
            chain_pos++;
        end else if (kind < 40) begin
            a = $urandom_range(0, live_count - 1);
            b = a;
        end else begin
            a = $urandom_range(0, live_count - 1);
            b = $urandom_range(0, live_count - 1);
        end
        send_item(CMD_UNION, IDX_W'(a), IDX_W'(b));
    endtask

    // Stimulus and verdict.
    initial begin
        int pick;
        int span;
        int phase;
        int n;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, starting from the reset setting of 26 nodes.
        send_item(CMD_UNION, 5'd0, 5'd1);
        send_item(CMD_UNION, 5'd25, 5'd0);
        send_item(CMD_UNION, 5'd26, 5'd0);
        send_item(CMD_UNION, 5'd0, 5'd31);
        send_item(CMD_UNION, 5'd1, 5'd0);
        send_item(CMD_CLEAR, 5'd31, 5'd31);
        write_node_count(32);
        send_clear();
        send_item(CMD_UNION, 5'd31, 5'd0);
        send_item(CMD_UNION, 5'd0, 5'd31);
        send_item(CMD_UNION, 5'd0, 5'd0);
        // No nodes in use: every union is flagged.
        write_node_count(0);
        send_clear();
        send_item(CMD_UNION, 5'd0, 5'd0);
        // A register above the table saturates, and only takes effect at a clear.
        write_node_count(63);
        send_item(CMD_UNION, 5'd0, 5'd31);
        send_clear();
        send_item(CMD_UNION, 5'd31, 5'd30);
        send_item(CMD_UNION, 5'd30, 5'd31);
        write_node_count(1);
        send_clear();
        send_item(CMD_UNION, 5'd0, 5'd0);
        send_item(CMD_UNION, 5'd1, 5'd0);
        send_item(CMD_UNION, 5'd31, 5'd31);

        // Random episodes: a new setting, usually a clear, then a run of unions.
        while (sent_items < ITEM_TARGET) begin
            phase = sent_items * 5 / ITEM_TARGET;
            case (phase)
                1: begin
                    send_idle_pct  = 82;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 82;
                end
                3: begin
                    send_idle_pct  = 37;
                    recv_stall_pct = 37;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase

            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                write_node_count(0);
            end else if (pick == 1) begin
                write_node_count(1);
            end else if (pick == 2) begin
                write_node_count($urandom_range(33, 63));
            end else if (pick == 3) begin
                write_node_count(32);
            end else if (pick < 12) begin
                write_node_count($urandom_range(2, 12));
            end else begin
                write_node_count($urandom_range(13, 31));
            end
            if ($urandom_range(0, 3) != 0) begin
                send_clear();
            end

            span = (live_count == 0) ? 6 : $urandom_range(15, 60);
            for (n = 0; n < span; n++) begin
                if ($urandom_range(0, 99) < 3) begin
                    send_clear();
                end else begin
                    send_random_union();
                end
            end
        end

        hold_until_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("union_find_component_counter verification clean");
        end else begin
            $display("union_find_component_counter verification failed");
        end
        $finish;
    end

endmodule
